// File: rtl/sbeq_pkg.sv
// shared types, constants and arithmetic helpers for the stereo equalizer
// no dependencies; used by every module of the block
package sbeq_pkg;

  // band count and signal format
  localparam int BAND_COUNT = 3;
  localparam int SIG_W      = 32;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 28;
  localparam int PCM_W      = 16;
  localparam int PCM_FRAC   = 8;

  // multiplier and accumulator widths
  localparam int PROD_W = SIG_W + COEF_W;
  localparam int TERM_W = PROD_W - COEF_FRAC;
  localparam int ACC_W  = TERM_W + 3;

  localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

  // configuration port
  localparam int CFG_DATA_W = 2 * COEF_W;
  localparam int REG_COUNT  = 2 * BAND_COUNT + 1;
  localparam int CFG_IDX_W  = $clog2(REG_COUNT);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(2 * BAND_COUNT);

  typedef logic signed [SIG_W-1:0]  sig_t;
  typedef logic signed [COEF_W-1:0] coef_w_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PCM_W-1:0]  pcm_t;

  localparam coef_w_t COEF_ONE = coef_w_t'(64'sd1 <<< COEF_FRAC);

  // coefficients of one band, b1 shared with a1
  typedef struct packed {
    coef_w_t b0;
    coef_w_t a1;
    coef_w_t b2;
    coef_w_t a2;
  } coef_t;

  typedef coef_t [BAND_COUNT-1:0] coef_bank_t;

  // status word from a lane to the merge stage
  typedef struct packed {
    logic done;
    sig_t y;
  } lane_res_t;

  localparam sig_t SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam sig_t SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  localparam pcm_t PCM_MAX = {1'b0, {(PCM_W-1){1'b1}}};
  localparam pcm_t PCM_MIN = {1'b1, {(PCM_W-1){1'b0}}};

  // clip limits in the signal format
  localparam sig_t Y_HI      = sig_t'(((64'sd1 <<< (PCM_W-1)) - 1) <<< PCM_FRAC);
  localparam sig_t Y_LO      = sig_t'(-(64'sd1 <<< (PCM_W-1)) <<< PCM_FRAC);
  localparam sig_t PCM_ROUND = sig_t'((64'sd1 <<< PCM_FRAC) - 1);

  // saturate the accumulator to the signal width
  function automatic sig_t sat_sig(acc_t a);
    logic [ACC_W-SIG_W:0] upper;
    upper = a[ACC_W-1:SIG_W-1];
    if ((&upper) || !(|upper)) begin
      return a[SIG_W-1:0];
    end else if (a[ACC_W-1]) begin
      return SIG_MIN;
    end else begin
      return SIG_MAX;
    end
  endfunction

  // clip to pcm and drop the fraction toward zero
  function automatic pcm_t to_pcm(sig_t y);
    sig_t adj;
    sig_t q;
    adj = y[SIG_W-1] ? y + PCM_ROUND : y;
    q   = adj >>> PCM_FRAC;
    if (y > Y_HI) begin
      return PCM_MAX;
    end else if (y < Y_LO) begin
      return PCM_MIN;
    end else begin
      return q[PCM_W-1:0];
    end
  endfunction

endpackage

// File: rtl/sbeq_lane.sv
// one channel lane: cascade of biquad bands on a single shared multiplier
// depends on sbeq_pkg
module sbeq_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sbeq_pkg::pcm_t      sample,
  input  sbeq_pkg::coef_bank_t coefs,
  input  logic                take,
  output sbeq_pkg::lane_res_t res
);
  import sbeq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_SAT, S_DONE} state_t;
  typedef enum logic [2:0] {TAP_B0, TAP_X1, TAP_X2, TAP_Y1, TAP_Y2} tap_t;

  state_t              state;
  tap_t                tap;
  logic [BAND_W-1:0]   band;
  sig_t                x_cur;
  sig_t                y_res;
  logic signed [PROD_W-1:0] prod;
  acc_t                acc;

  // per band history of this channel
  sig_t hx1 [BAND_COUNT];
  sig_t hx2 [BAND_COUNT];
  sig_t hy1 [BAND_COUNT];
  sig_t hy2 [BAND_COUNT];

  coef_t                    c;
  coef_w_t                  mc;
  sig_t                     mv;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [TERM_W-1:0] term;
  acc_t                     acc_next;
  sig_t                     y_sat;

  // operand select for the current tap
  always_comb begin
    c = coefs[band];
    case (tap)
      TAP_B0:  begin mc = c.b0; mv = x_cur;     end
      TAP_X1:  begin mc = c.a1; mv = hx1[band]; end
      TAP_X2:  begin mc = c.b2; mv = hx2[band]; end
      TAP_Y1:  begin mc = c.a1; mv = hy1[band]; end
      TAP_Y2:  begin mc = c.a2; mv = hy2[band]; end
      default: begin mc = c.b0; mv = x_cur;     end
    endcase
    prod_next = PROD_W'(mc) * PROD_W'(mv);
  end

  // floor of the product into signal format, feedback taps subtract
  always_comb begin
    term = $signed(prod[PROD_W-1:COEF_FRAC]);
    if (tap == TAP_Y1 || tap == TAP_Y2) begin
      acc_next = acc - ACC_W'(term);
    end else begin
      acc_next = acc + ACC_W'(term);
    end
    y_sat = sat_sig(acc);
  end

  // sequencer: multiply, accumulate, then saturate and shift history
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= TAP_B0;
      band  <= '0;
      for (int b = 0; b < BAND_COUNT; b++) begin
        hx1[b] <= '0;
        hx2[b] <= '0;
        hy1[b] <= '0;
        hy2[b] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            x_cur <= SIG_W'(sample) <<< PCM_FRAC;
            band  <= '0;
            tap   <= TAP_B0;
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc_next;
          case (tap)
            TAP_B0:  begin tap <= TAP_X1; state <= S_MUL; end
            TAP_X1:  begin tap <= TAP_X2; state <= S_MUL; end
            TAP_X2:  begin tap <= TAP_Y1; state <= S_MUL; end
            TAP_Y1:  begin tap <= TAP_Y2; state <= S_MUL; end
            default: begin tap <= TAP_B0; state <= S_SAT; end
          endcase
        end
        S_SAT: begin
          hx2[band] <= hx1[band];
          hx1[band] <= x_cur;
          hy2[band] <= hy1[band];
          hy1[band] <= y_sat;
          x_cur     <= y_sat;
          if (band == BAND_W'(BAND_COUNT - 1)) begin
            y_res <= y_sat;
            state <= S_DONE;
          end else begin
            band  <= band + BAND_W'(1);
            tap   <= TAP_B0;
            acc   <= '0;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.done = (state == S_DONE);
  assign res.y    = y_res;

endmodule

// File: rtl/sbeq_merge.sv
// merge stage: joins both lanes, clips to pcm, selects bypass, output register
// depends on sbeq_pkg
module sbeq_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                enable,
  input  sbeq_pkg::pcm_t      left_raw,
  input  sbeq_pkg::pcm_t      right_raw,
  input  sbeq_pkg::lane_res_t lane_l,
  input  sbeq_pkg::lane_res_t lane_r,
  output logic                take,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output sbeq_pkg::pcm_t      left_out,
  output sbeq_pkg::pcm_t      right_out
);
  import sbeq_pkg::*;

  logic pending;
  logic bypass;
  pcm_t raw_l;
  pcm_t raw_r;
  logic load;

  // result ready and output register free
  assign load = pending && (bypass || (lane_l.done && lane_r.done))
                && (!out_valid || out_ready);
  assign take = load && !bypass;
  assign busy = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // capture the raw word and mode at accept
      if (start) begin
        pending <= 1'b1;
        bypass  <= !enable;
        raw_l   <= left_raw;
        raw_r   <= right_raw;
      end
      // hand the finished word to the output register
      if (load) begin
        pending   <= 1'b0;
        out_valid <= 1'b1;
        left_out  <= bypass ? raw_l : to_pcm(lane_l.y);
        right_out <= bypass ? raw_r : to_pcm(lane_r.y);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/stereo_three_band_biquad_eq.sv
// top level of the stereo three band equalizer: config registers, two lanes, merge
// depends on sbeq_pkg, sbeq_lane, sbeq_merge
//
//  port group          | direction | handshake         | word
//  --------------------+-----------+-------------------+---------------------------
//  in                  | in        | in_valid/in_ready | left_in, right_in
//  out                 | out       | out_valid/out_ready | left_out, right_out
//  cfg                 | in        | cfg_we            | cfg_index, cfg_data
//
// one word at a time; each lane runs 5 multiply/accumulate pairs plus one
// saturate step per band on its own multiplier. in_ready returns once the word
// sits in the output register, so the next word is taken while out_valid waits
// on out_ready.
// synchronous reset clears history, control and loads the unity coefficients.
module stereo_three_band_biquad_eq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sbeq_pkg::pcm_t                      left_in,
  input  sbeq_pkg::pcm_t                      right_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sbeq_pkg::pcm_t                      left_out,
  output sbeq_pkg::pcm_t                      right_out,
  input  logic                                cfg_we,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbeq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sbeq_pkg::*;

  coef_bank_t coefs;
  logic       eq_enable;
  logic       in_accept;
  logic       lane_start;
  logic       take;
  logic       busy;
  lane_res_t  lane_l;
  lane_res_t  lane_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        coefs[b].b0 <= COEF_ONE;
        coefs[b].a1 <= '0;
        coefs[b].b2 <= '0;
        coefs[b].a2 <= '0;
      end
      eq_enable <= 1'b1;
    end else if (cfg_we) begin
      for (int b = 0; b < BAND_COUNT; b++) begin
        if (cfg_index == CFG_IDX_W'(2 * b)) begin
          coefs[b].b0 <= cfg_data[CFG_DATA_W-1:COEF_W];
          coefs[b].b2 <= cfg_data[COEF_W-1:0];
        end
        if (cfg_index == CFG_IDX_W'(2 * b + 1)) begin
          coefs[b].a1 <= cfg_data[CFG_DATA_W-1:COEF_W];
          coefs[b].a2 <= cfg_data[COEF_W-1:0];
        end
      end
      if (cfg_index == REG_ENABLE) begin
        eq_enable <= cfg_data[0];
      end
    end
  end

  // input handshake
  assign in_ready   = !busy;
  assign in_accept  = in_valid && in_ready;
  assign lane_start = in_accept && eq_enable;

  // one lane per channel
  sbeq_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .sample (left_in),
    .coefs  (coefs),
    .take   (take),
    .res    (lane_l)
  );

  sbeq_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .sample (right_in),
    .coefs  (coefs),
    .take   (take),
    .res    (lane_r)
  );

  sbeq_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (in_accept),
    .enable    (eq_enable),
    .left_raw  (left_in),
    .right_raw (right_in),
    .lane_l    (lane_l),
    .lane_r    (lane_r),
    .take      (take),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

endmodule

// File: rtl/sbeq_checker.sv
// port level checks for the stereo equalizer, bound to the top level
// depends on sbeq_pkg and stereo_three_band_biquad_eq
module sbeq_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sbeq_pkg::pcm_t left_out,
  input sbeq_pkg::pcm_t right_out
);
  import sbeq_pkg::*;

  // words accepted and not yet delivered
  logic [1:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   in_flight <= in_flight + 2'd1;
        2'b01:   in_flight <= in_flight - 2'd1;
        default: in_flight <= in_flight;
      endcase
    end
  end

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("output word changed while stalled");

  // only one word in processing at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // no invented results
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 2'd0)
    else $error("output valid with nothing accepted");

  // at most one processing and one waiting
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_flight == 2'd2 |-> !in_ready)
    else $error("input ready while pipeline full");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind stereo_three_band_biquad_eq sbeq_checker u_sbeq_checker (.*);
